// ===== hdl/mssm_pkg.sv =====
// Shared types and constants for the multi-stack shared memory block.
// Used by mssm_front, mssm_queue, mssm_back and multi_stack_shared_memory_top.
package mssm_pkg;

  // Default sizes.
  localparam int unsigned NumStacksDef = 8;
  localparam int unsigned MemDepthDef  = 256;
  localparam int unsigned DataWidthDef = 32;

  // Field widths.
  localparam int unsigned ActionW   = 2;
  localparam int unsigned SelW      = 3;
  localparam int unsigned ValueW    = 32;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned LenW      = 6;
  localparam int unsigned ActiveW   = 4;
  localparam int unsigned CapW      = 6;
  localparam int unsigned CfgDataW  = 6;
  localparam int unsigned CfgIndexW = 1;

  // Slot address before the memory range check: 7 * 63 + 63 fits in 9 bits.
  localparam int unsigned SlotAddrW = 9;

  // Entries in the queue between front and back.
  localparam int unsigned QueueDepth = 2;

  // Reset values of the configuration registers.
  localparam logic [ActiveW-1:0] ActiveReset = 4'd8;
  localparam logic [CapW-1:0]    CapReset    = 6'd32;

  typedef enum logic [ActionW-1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_QUERY = 2'd2
  } action_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_OVER     = 2'd1,
    ST_UNDER    = 2'd2,
    ST_INACTIVE = 2'd3
  } status_e;

  typedef enum logic [CfgIndexW-1:0] {
    REG_ACTIVE_STACKS = 1'd0,
    REG_SLOT_CAPACITY = 1'd1
  } cfg_reg_e;

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic                 wr_en;
    logic                 rd_en;
    logic [SlotAddrW-1:0] slot_addr;
    logic [ValueW-1:0]    push_value;
    status_e              status;
    logic [LenW-1:0]      stack_length;
  } op_t;

endpackage

// ===== hdl/mssm_front.sv =====
// Front end: configuration registers, per-stack fill counts and request classification.
// Depends on mssm_pkg.
module mssm_front #(
  parameter int unsigned NUM_STACKS = mssm_pkg::NumStacksDef,
  parameter int unsigned MEM_DEPTH  = mssm_pkg::MemDepthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_wr_en_i,
  input  logic [mssm_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  logic [mssm_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            accept_i,
  input  logic [mssm_pkg::ActionW-1:0]    action_i,
  input  logic [mssm_pkg::SelW-1:0]       stack_sel_i,
  input  logic [mssm_pkg::ValueW-1:0]     push_value_i,
  output mssm_pkg::op_t                   op_o
);

  localparam int unsigned IdxW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

  logic [mssm_pkg::ActiveW-1:0]   active_q;
  logic [mssm_pkg::CapW-1:0]      cap_q;
  logic [mssm_pkg::LenW-1:0]      fill_q [NUM_STACKS];

  logic [IdxW-1:0]                sel_idx;
  logic                           sel_ok;
  logic [mssm_pkg::LenW-1:0]      fill_cur;
  logic [mssm_pkg::LenW-1:0]      fill_nx;
  logic                           fill_upd;
  logic [mssm_pkg::SlotAddrW-1:0] base;
  logic [mssm_pkg::SlotAddrW-1:0] push_addr;
  logic [mssm_pkg::SlotAddrW-1:0] pop_addr;
  logic                           push_in_mem;
  logic                           pop_in_mem;

  always_comb begin
    sel_idx = '0;
    for (int b = 0; b < IdxW; b++) begin
      if (b < mssm_pkg::SelW) begin
        sel_idx[b] = stack_sel_i[b];
      end
    end
  end

  assign sel_ok = ({28'd0, active_q} > {29'd0, stack_sel_i}) &&
                  ({29'd0, stack_sel_i} < 32'(NUM_STACKS));
  assign fill_cur = sel_ok ? fill_q[sel_idx] : '0;

  assign base        = {3'd0, cap_q} * {6'd0, stack_sel_i};
  assign push_addr   = base + {3'd0, fill_cur};
  assign pop_addr    = base + {3'd0, fill_cur} - 9'd1;
  assign push_in_mem = 32'(push_addr) < 32'(MEM_DEPTH);
  assign pop_in_mem  = 32'(pop_addr) < 32'(MEM_DEPTH);

  always_comb begin
    op_o            = '0;
    op_o.push_value = push_value_i;
    op_o.status     = mssm_pkg::ST_OK;
    fill_nx         = fill_cur;
    fill_upd        = 1'b0;
    if (!sel_ok) begin
      op_o.status = mssm_pkg::ST_INACTIVE;
    end else begin
      unique case (mssm_pkg::action_e'(action_i))
        mssm_pkg::ACT_PUSH: begin
          op_o.slot_addr = push_addr;
          if (fill_cur >= cap_q || !push_in_mem) begin
            op_o.status = mssm_pkg::ST_OVER;
          end else begin
            op_o.wr_en = 1'b1;
            fill_nx    = fill_cur + 6'd1;
            fill_upd   = 1'b1;
          end
        end
        mssm_pkg::ACT_POP: begin
          op_o.slot_addr = pop_addr;
          if (fill_cur == '0) begin
            op_o.status = mssm_pkg::ST_UNDER;
          end else begin
            // A slot beyond the memory reads as zero, but the fill still drops.
            op_o.rd_en = pop_in_mem;
            fill_nx    = fill_cur - 6'd1;
            fill_upd   = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    op_o.stack_length = fill_nx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= mssm_pkg::ActiveReset;
      cap_q    <= mssm_pkg::CapReset;
      for (int k = 0; k < NUM_STACKS; k++) begin
        fill_q[k] <= '0;
      end
    end else begin
      if (cfg_wr_en_i) begin
        unique case (mssm_pkg::cfg_reg_e'(cfg_index_i))
          mssm_pkg::REG_ACTIVE_STACKS: active_q <= cfg_data_i[mssm_pkg::ActiveW-1:0];
          mssm_pkg::REG_SLOT_CAPACITY: cap_q    <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (accept_i && fill_upd) begin
        fill_q[sel_idx] <= fill_nx;
      end
    end
  end

endmodule

// ===== hdl/mssm_queue.sv =====
// Short queue of classified requests between the front and the back.
// Depends on mssm_pkg.
module mssm_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  mssm_pkg::op_t wr_op_i,
  output logic          full_o,
  input  logic          rd_en_i,
  output logic          valid_o,
  output mssm_pkg::op_t rd_op_o
);

  localparam int unsigned PtrW = (mssm_pkg::QueueDepth > 1) ? $clog2(mssm_pkg::QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(mssm_pkg::QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(mssm_pkg::QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(mssm_pkg::QueueDepth);

  mssm_pkg::op_t   entry_q [mssm_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_wr;
  logic            do_rd;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign rd_op_o = entry_q[rd_ptr_q];
  assign do_wr   = wr_en_i && !full_o;
  assign do_rd   = rd_en_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      entry_q[wr_ptr_q] <= wr_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({do_wr, do_rd})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== hdl/mssm_back.sv =====
// Back end: the shared slot memory and the result register.
// Depends on mssm_pkg.
module mssm_back #(
  parameter int unsigned MEM_DEPTH  = mssm_pkg::MemDepthDef,
  parameter int unsigned DATA_WIDTH = mssm_pkg::DataWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           op_valid_i,
  input  mssm_pkg::op_t                  op_i,
  output logic                           op_take_o,
  output logic                           empty,
  input  logic                           pop,
  output logic [mssm_pkg::ValueW-1:0]    pop_value_o,
  output logic [mssm_pkg::StatusW-1:0]   status_o,
  output logic [mssm_pkg::LenW-1:0]      stack_length_o
);

  localparam int unsigned AddrW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  logic [DATA_WIDTH-1:0]      mem [MEM_DEPTH];
  logic [DATA_WIDTH-1:0]      rd_data_q;
  logic                       out_valid_q;
  logic                       out_hit_q;
  mssm_pkg::status_e          out_status_q;
  logic [mssm_pkg::LenW-1:0]  out_len_q;

  logic [AddrW-1:0]           mem_addr;
  logic [DATA_WIDTH-1:0]      wr_data;
  logic                       issue;

  // Issue when the result register is free or is being drained this cycle.
  assign issue     = op_valid_i && (!out_valid_q || pop);
  assign op_take_o = issue;

  always_comb begin
    mem_addr = '0;
    for (int b = 0; b < AddrW; b++) begin
      if (b < mssm_pkg::SlotAddrW) begin
        mem_addr[b] = op_i.slot_addr[b];
      end
    end
    wr_data = '0;
    for (int b = 0; b < DATA_WIDTH; b++) begin
      if (b < mssm_pkg::ValueW) begin
        wr_data[b] = op_i.push_value[b];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue && op_i.wr_en) begin
      mem[mem_addr] <= wr_data;
    end
    if (issue && op_i.rd_en) begin
      rd_data_q <= mem[mem_addr];
    end
    if (issue) begin
      out_status_q <= op_i.status;
      out_len_q    <= op_i.stack_length;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_hit_q   <= 1'b0;
    end else begin
      if (issue) begin
        out_valid_q <= 1'b1;
        out_hit_q   <= op_i.rd_en;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    pop_value_o = '0;
    for (int b = 0; b < mssm_pkg::ValueW; b++) begin
      if (b < DATA_WIDTH) begin
        pop_value_o[b] = out_hit_q & rd_data_q[b];
      end
    end
  end

  assign empty          = !out_valid_q;
  assign status_o       = out_status_q;
  assign stack_length_o = out_len_q;

endmodule

// ===== hdl/multi_stack_shared_memory_top.sv =====
// Top level of the multi-stack shared memory block.
// Depends on mssm_pkg, mssm_front, mssm_queue and mssm_back.
//
//   Channel   Handshake           Payload
//   request   push / full         action_i, stack_sel_i, push_value_i
//   result    empty / pop         pop_value_o, status_o, stack_length_o
//   config    cfg_wr_en_i         cfg_index_i, cfg_data_i
//
// One request per cycle in and one result per cycle out when pop is held high.
// A result passes through the request queue and then the registered memory
// read. Fill counts live in the front, so there is no hazard between
// back-to-back requests. Reset clears all fill counts at once; slot contents
// are not cleared. A stalled result side fills the queue and then raises full.
module multi_stack_shared_memory_top #(
  parameter int unsigned NUM_STACKS = mssm_pkg::NumStacksDef,
  parameter int unsigned MEM_DEPTH  = mssm_pkg::MemDepthDef,
  parameter int unsigned DATA_WIDTH = mssm_pkg::DataWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_wr_en_i,
  input  logic [mssm_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [mssm_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           push,
  output logic                           full,
  input  logic [mssm_pkg::ActionW-1:0]   action_i,
  input  logic [mssm_pkg::SelW-1:0]      stack_sel_i,
  input  logic [mssm_pkg::ValueW-1:0]    push_value_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [mssm_pkg::ValueW-1:0]    pop_value_o,
  output logic [mssm_pkg::StatusW-1:0]   status_o,
  output logic [mssm_pkg::LenW-1:0]      stack_length_o
);

  mssm_pkg::op_t front_op;
  mssm_pkg::op_t queue_op;
  logic          accept;
  logic          queue_full;
  logic          queue_valid;
  logic          queue_take;

  assign full   = queue_full;
  assign accept = push && !queue_full;

  mssm_front #(
    .NUM_STACKS (NUM_STACKS),
    .MEM_DEPTH  (MEM_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_wr_en_i  (cfg_wr_en_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .accept_i     (accept),
    .action_i     (action_i),
    .stack_sel_i  (stack_sel_i),
    .push_value_i (push_value_i),
    .op_o         (front_op)
  );

  mssm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (accept),
    .wr_op_i (front_op),
    .full_o  (queue_full),
    .rd_en_i (queue_take),
    .valid_o (queue_valid),
    .rd_op_o (queue_op)
  );

  mssm_back #(
    .MEM_DEPTH  (MEM_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_valid_i     (queue_valid),
    .op_i           (queue_op),
    .op_take_o      (queue_take),
    .empty          (empty),
    .pop            (pop),
    .pop_value_o    (pop_value_o),
    .status_o       (status_o),
    .stack_length_o (stack_length_o)
  );

endmodule

// ===== bench/tb_multi_stack_shared_memory_top.sv =====
// Testbench for multi_stack_shared_memory_top: random and directed stack requests,
// with results checked against a cycle-free model of the stacks kept in this file.
// Depends on mssm_pkg and the RTL of multi_stack_shared_memory_top.
module tb_multi_stack_shared_memory_top;
  import mssm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ClkPeriod = 10;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles = 4;

  // Two copies of the stack state: one tracks what has been queued, one what was accepted.
  localparam int PlanCopy = 0;
  localparam int ModelCopy = 1;

  // The spare action code behaves as a length query.
  localparam logic [ActionW-1:0] ActSpare = 2'd3;

  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [SelW-1:0]    sel;
    logic [ValueW-1:0]  value;
  } stack_req_t;

  typedef struct packed {
    logic [ValueW-1:0] pop_value;
    status_e           status;
    logic [LenW-1:0]   stack_length;
  } stack_resp_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_wr_en_i;
  logic [CfgIndexW-1:0] cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic push;
  logic full;
  logic [ActionW-1:0] action_i;
  logic [SelW-1:0] stack_sel_i;
  logic [ValueW-1:0] push_value_i;
  logic empty;
  logic pop;
  logic [ValueW-1:0] pop_value_o;
  logic [StatusW-1:0] status_o;
  logic [LenW-1:0] stack_length_o;

  logic [ValueW-1:0] slot_mem [2][MemDepthDef];
  bit slot_written [2][MemDepthDef];
  bit [LenW-1:0] stack_fill [2][NumStacksDef];
  logic [ActiveW-1:0] active_reg [2];
  logic [CapW-1:0] cap_reg [2];

  stack_req_t req_backlog [$];
  stack_resp_t resp_expected [$];
  bit req_granted;
  int unsigned burst_left;
  int unsigned gap_left;
  logic [15:0] stall_pat;
  logic [3:0] stall_step;
  int unsigned mismatches;
  int unsigned quiet_cycles;

  multi_stack_shared_memory_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .push          (push),
    .full          (full),
    .action_i      (action_i),
    .stack_sel_i   (stack_sel_i),
    .push_value_i  (push_value_i),
    .empty         (empty),
    .pop           (pop),
    .pop_value_o   (pop_value_o),
    .status_o      (status_o),
    .stack_length_o(stack_length_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic void set_reg(input int cp, input logic [CfgIndexW-1:0] idx,
                                  input logic [CfgDataW-1:0] data);
    if (idx == REG_ACTIVE_STACKS) begin
      active_reg[cp] = data[ActiveW-1:0];
    end else begin
      cap_reg[cp] = data[CapW-1:0];
    end
  endfunction

  function automatic int unsigned live_stacks(input int cp);
    return (active_reg[cp] > NumStacksDef) ? NumStacksDef : active_reg[cp];
  endfunction

  // Apply one request to the chosen copy of the stacks and return its result.
  function automatic stack_resp_t stack_op(input int cp, input stack_req_t r);
    stack_resp_t res;
    int unsigned sel_n;
    int unsigned fill_n;
    int unsigned addr;
    res.pop_value = '0;
    res.status = ST_OK;
    res.stack_length = '0;
    sel_n = r.sel;
    if (sel_n >= live_stacks(cp)) begin
      res.status = ST_INACTIVE;
    end else begin
      fill_n = stack_fill[cp][sel_n];
      if (r.action == ACT_PUSH) begin
        addr = sel_n * cap_reg[cp] + fill_n;
        if (fill_n >= cap_reg[cp] || addr >= MemDepthDef) begin
          res.status = ST_OVER;
        end else begin
          slot_mem[cp][addr] = r.value;
          slot_written[cp][addr] = 1'b1;
          fill_n++;
        end
      end else if (r.action == ACT_POP) begin
        if (fill_n == 0) begin
          res.status = ST_UNDER;
        end else begin
          addr = sel_n * cap_reg[cp] + fill_n - 1;
          if (addr < MemDepthDef) res.pop_value = slot_mem[cp][addr];
          fill_n--;
        end
      end
      stack_fill[cp][sel_n] = fill_n[LenW-1:0];
      res.stack_length = fill_n[LenW-1:0];
    end
    return res;
  endfunction

  task automatic queue_request(input logic [ActionW-1:0] act, input logic [SelW-1:0] sel,
                               input logic [ValueW-1:0] val);
    stack_req_t r;
    int unsigned slot;
    r.action = act;
    r.sel = sel;
    r.value = val;
    // turn a pop of a slot never written into a query
    if (act == ACT_POP && sel < live_stacks(PlanCopy) && stack_fill[PlanCopy][sel] != 0) begin
      slot = int'(sel) * cap_reg[PlanCopy] + stack_fill[PlanCopy][sel] - 1;
      if (slot < MemDepthDef && !slot_written[PlanCopy][slot]) r.action = ACT_QUERY;
    end
    void'(stack_op(PlanCopy, r));
    req_backlog.push_back(r);
  endtask

  task automatic random_traffic(input int unsigned count);
    int unsigned push_pct;
    int unsigned roll;
    logic [SelW-1:0] sel;
    logic [ActionW-1:0] act;
    logic [ValueW-1:0] val;
    push_pct = 60;
    for (int unsigned i = 0; i < count; i++) begin
      // swing between filling and draining so stacks hit both ends
      if ($urandom_range(0, 39) == 0) push_pct = $urandom_range(15, 85);
      if (live_stacks(PlanCopy) != 0 && $urandom_range(0, 9) != 0) begin
        sel = SelW'($urandom_range(0, live_stacks(PlanCopy) - 1));
      end else begin
        sel = SelW'($urandom_range(0, NumStacksDef - 1));
      end
      roll = $urandom_range(0, 99);
      if (roll < 4) act = ACT_QUERY;
      else if (roll < 8) act = ActSpare;
      else if (roll < 8 + push_pct * 92 / 100) act = ACT_PUSH;
      else act = ACT_POP;
      case ($urandom_range(0, 9))
        0: val = '0;
        1: val = '1;
        default: val = $urandom;
      endcase
      queue_request(act, sel, val);
    end
  endtask

  task automatic wait_idle();
    while (req_backlog.size() != 0 || resp_expected.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_wr_en_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    set_reg(PlanCopy, idx, data);
    @(negedge clk_i);
    cfg_wr_en_i <= 1'b0;
  endtask

  task automatic configure(input logic [CfgDataW-1:0] stacks, input logic [CfgDataW-1:0] cap);
    wait_idle();
    write_reg(REG_ACTIVE_STACKS, stacks);
    write_reg(REG_SLOT_CAPACITY, cap);
  endtask

  // Request side: accept at the rising edge, drive at the falling edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_wr_en_i) set_reg(ModelCopy, cfg_index_i, cfg_data_i);
      if (push && !full) begin
        resp_expected.push_back(stack_op(ModelCopy, req_backlog.pop_front()));
        req_granted = 1'b1;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!push || req_granted)) begin
      req_granted = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
        push <= 1'b0;
      end else if (req_backlog.size() == 0) begin
        push <= 1'b0;
      end else begin
        push <= 1'b1;
        action_i <= req_backlog[0].action;
        stack_sel_i <= req_backlog[0].sel;
        push_value_i <= req_backlog[0].value;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // Result side: stall on a rotating pattern, reloaded each time the 4-bit step counter wraps.
  always @(negedge clk_i) begin
    if (stall_step == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pat = 16'hffff;
        3: stall_pat = 16'($urandom & $urandom);
        default: stall_pat = 16'($urandom);
      endcase
    end
    pop <= stall_pat[stall_step];
    stall_step <= stall_step + 4'd1;
  end

  always @(posedge clk_i) begin
    stack_resp_t exp_resp;
    if (rst_ni && pop && !empty) begin
      if (resp_expected.size() == 0) begin
        $display("%0t: result with no request pending: pop_value %h status %0d length %0d",
                 $time, pop_value_o, status_o, stack_length_o);
        mismatches++;
      end else begin
        exp_resp = resp_expected.pop_front();
        if (pop_value_o !== exp_resp.pop_value) begin
          $display("%0t: pop_value expected %h actual %h", $time, exp_resp.pop_value,
                   pop_value_o);
          mismatches++;
        end
        if (status_o !== exp_resp.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_resp.status, status_o);
          mismatches++;
        end
        if (stack_length_o !== exp_resp.stack_length) begin
          $display("%0t: stack_length expected %0d actual %0d", $time,
                   exp_resp.stack_length, stack_length_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || cfg_wr_en_i) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles == WatchdogLimit) begin
      $display("%0t: no progress for %0d cycles", $time, WatchdogLimit);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_wr_en_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    push = 1'b0;
    pop = 1'b0;
    action_i = '0;
    stack_sel_i = '0;
    push_value_i = '0;
    stall_pat = '0;
    stall_step = '0;
    for (int cp = 0; cp < 2; cp++) begin
      active_reg[cp] = ActiveReset;
      cap_reg[cp] = CapReset;
    end
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset sizes: extremes of the value, every action, underflow.
    configure(6'd8, 6'd32);
    queue_request(ACT_PUSH, 3'd0, 32'h0000_0000);
    queue_request(ACT_PUSH, 3'd0, 32'hffff_ffff);
    queue_request(ACT_PUSH, 3'd7, 32'ha5a5_5a5a);
    queue_request(ACT_POP, 3'd0, 32'h1234_5678);
    queue_request(ACT_POP, 3'd0, 32'h0);
    queue_request(ACT_POP, 3'd0, 32'h0);
    queue_request(ACT_QUERY, 3'd0, 32'h0);
    queue_request(ActSpare, 3'd7, 32'hffff_ffff);
    queue_request(ACT_POP, 3'd7, 32'h0);
    queue_request(ACT_POP, 3'd7, 32'h0);
    queue_request(ACT_PUSH, 3'd3, 32'h1234_5678);
    queue_request(ActSpare, 3'd3, 32'h0);
    random_traffic(250);

    // Clamped stack count; upper stacks run past the end of memory.
    configure(6'd15, 6'd40);
    random_traffic(200);

    // One slot per stack: pushes overflow once the slot is taken, fills kept from before.
    configure(6'd8, 6'd1);
    queue_request(ACT_PUSH, 3'd2, 32'h0000_0001);
    queue_request(ACT_PUSH, 3'd2, 32'h8000_0000);
    queue_request(ACT_POP, 3'd2, 32'h0);
    queue_request(ACT_POP, 3'd2, 32'h0);
    random_traffic(150);

    configure(6'd1, 6'd63);
    random_traffic(250);

    // Nothing active, zero capacity.
    configure(6'd0, 6'd0);
    random_traffic(60);

    configure(6'd8, 6'd0);
    random_traffic(100);

    // Stacks above the active count are refused.
    configure(6'd4, 6'd12);
    queue_request(ACT_PUSH, 3'd4, 32'hdead_beef);
    queue_request(ACT_POP, 3'd7, 32'h0);
    queue_request(ACT_QUERY, 3'd5, 32'h0);
    random_traffic(200);

    configure(6'd8, 6'd32);
    random_traffic(250);

    repeat (4) begin
      configure(6'($urandom_range(0, 15)), 6'($urandom_range(0, 63)));
      random_traffic(100);
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
